### rtl/core/wbss_pkg.sv
// shared types and constants of the wildcard byte stream search
package wbss_pkg;

   localparam int MAX_PATTERN  = 16;
   localparam int BYTE_W       = 8;
   localparam int IDX_W        = $clog2(MAX_PATTERN);
   localparam int LEN_W        = 5;
   localparam int POS_W        = 15;
   localparam int CNT_W        = 15;
   localparam int LSTART_W     = 16;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 64;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [BYTE_W-1:0]   WILD_BYTE    = 8'h3F;
   localparam logic [BYTE_W-1:0]   NEWLINE_BYTE = 8'h0A;
   localparam logic [BYTE_W-1:0]   CASE_OFFSET  = 8'h20;
   localparam logic [POS_W-1:0]    POS_MAX      = '1;
   localparam logic [CNT_W-1:0]    CNT_MAX      = '1;
   localparam logic [LEN_W-1:0]    LEN_RESET    = 5'd1;
   localparam logic [LEN_W-1:0]    LEN_LIMIT    = LEN_W'(MAX_PATTERN);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PATTERN_LOW  = 3'd0,
      REG_PATTERN_HIGH = 3'd1,
      REG_PATTERN_LEN  = 3'd2,
      REG_FOLD_CASE    = 3'd3,
      REG_WILDCARD     = 3'd4,
      REG_WHOLE_WORD   = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic [MAX_PATTERN-1:0][BYTE_W-1:0] pattern;
      logic [IDX_W-1:0]                   len_idx;
      logic                               fold_case;
      logic                               wildcard_enable;
      logic                               whole_word;
   } cfg_type;

   typedef struct packed {
      logic [MAX_PATTERN-1:0] eq;
      logic                   is_sep;
      logic                   is_nl;
      logic                   first;
      logic                   last;
   } item_type;

endpackage

### rtl/core/wbss_if.sv
// handshake channel interfaces of the wildcard byte stream search
interface wbss_req_if;
   logic                          valid;
   logic                          ready;
   logic [wbss_pkg::BYTE_W-1:0]   data_byte;
   logic                          first_byte;
   logic                          last_byte;

   modport source (output valid, data_byte, first_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface wbss_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            found;
   logic [wbss_pkg::POS_W-1:0]      match_start;
   logic [wbss_pkg::CNT_W-1:0]      line_count;
   logic [wbss_pkg::LSTART_W-1:0]   line_start;

   modport source (output valid, found, match_start, line_count, line_start, input ready);
   modport sink   (input valid, found, match_start, line_count, line_start, output ready);
endinterface

interface wbss_csr_if;
   logic                              valid;
   logic                              ready;
   logic [wbss_pkg::CSR_IDX_W-1:0]    index;
   logic [wbss_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/wildcard_byte_stream_search.sv
// top level of the wildcard byte stream search
// Scans a buffer one byte per item on req_chan and reports the first
// occurrence of the configured pattern (up to 16 bytes) on rsp_chan.
// The pattern, its length and the fold-case, wildcard and whole-word options
// are written on csr_chan, register index in index, value in data; csr_chan
// is always ready and must only be written while no search is in flight.
// An item with first_byte set starts a new search; last_byte marks the end
// of the buffer. Each buffer gives one result: a match (start position, line
// count and line start), or not-found on the last byte. Bytes after a result
// are dropped until the next first_byte.
// Throughput is one byte per cycle while rsp_chan does not stall: the input
// stage classifies a byte in the cycle it is taken, a four-entry queue holds
// it, and the search engine updates its shift-and state once per byte.
// A taken byte is stored in the queue; the result is registered when the engine
// takes the byte that ends the search. A whole-word match that ends before the
// buffer end is reported on the following byte, if that byte is a separator.
// When rsp_chan stalls, the result register holds and the engine halts;
// req_chan keeps accepting until the queue fills.
// Reset (synchronous, active high) restores the configuration registers to
// their defaults and clears the search state, result valid flag and queue.
module wildcard_byte_stream_search (
   input  logic        clock,
   input  logic        reset,
   wbss_req_if.sink    req_chan,
   wbss_rsp_if.source  rsp_chan,
   wbss_csr_if.sink    csr_chan
);

   wbss_pkg::cfg_type  cfg;
   wbss_pkg::item_type front_item;
   wbss_pkg::item_type back_item;
   logic               push;
   logic               q_ready;
   logic               q_valid;
   logic               pop;

   wbss_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   wbss_front u_front (
      .cfg      (cfg),
      .req_chan (req_chan),
      .q_ready  (q_ready),
      .push     (push),
      .item     (front_item)
   );

   wbss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (front_item),
      .push_ready (q_ready),
      .pop_valid  (q_valid),
      .pop        (pop),
      .pop_item   (back_item)
   );

   wbss_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .q_valid  (q_valid),
      .q_item   (back_item),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

### rtl/core/wbss_csr.sv
// configuration registers of the search
module wbss_csr (
   input  logic              clock,
   input  logic              reset,
   wbss_csr_if.sink          csr_chan,
   output wbss_pkg::cfg_type cfg
);

   logic [wbss_pkg::CSR_DATA_W-1:0] pat_lo_ff, pat_lo_in;
   logic [wbss_pkg::CSR_DATA_W-1:0] pat_hi_ff, pat_hi_in;
   logic [wbss_pkg::LEN_W-1:0]      len_ff, len_in;
   logic                            fold_ff, fold_in;
   logic                            wild_ff, wild_in;
   logic                            word_ff, word_in;
   logic                            wr_en;

   assign csr_chan.ready = 1'b1;
   assign wr_en = csr_chan.valid && csr_chan.ready;

   always_comb begin
      pat_lo_in = pat_lo_ff;
      pat_hi_in = pat_hi_ff;
      len_in    = len_ff;
      fold_in   = fold_ff;
      wild_in   = wild_ff;
      word_in   = word_ff;
      if (wr_en) begin
         case (csr_chan.index)
            wbss_pkg::REG_PATTERN_LOW:  pat_lo_in = csr_chan.data;
            wbss_pkg::REG_PATTERN_HIGH: pat_hi_in = csr_chan.data;
            wbss_pkg::REG_PATTERN_LEN:  len_in    = csr_chan.data[wbss_pkg::LEN_W-1:0];
            wbss_pkg::REG_FOLD_CASE:    fold_in   = csr_chan.data[0];
            wbss_pkg::REG_WILDCARD:     wild_in   = csr_chan.data[0];
            wbss_pkg::REG_WHOLE_WORD:   word_in   = csr_chan.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_lo_ff <= '0;
         pat_hi_ff <= '0;
         len_ff    <= wbss_pkg::LEN_RESET;
         fold_ff   <= 1'b0;
         wild_ff   <= 1'b0;
         word_ff   <= 1'b0;
      end else begin
         pat_lo_ff <= pat_lo_in;
         pat_hi_ff <= pat_hi_in;
         len_ff    <= len_in;
         fold_ff   <= fold_in;
         wild_ff   <= wild_in;
         word_ff   <= word_in;
      end
   end

   // zero length acts as one, lengths past the pattern size are clamped
   always_comb begin
      cfg.pattern         = {pat_hi_ff, pat_lo_ff};
      cfg.fold_case       = fold_ff;
      cfg.wildcard_enable = wild_ff;
      cfg.whole_word      = word_ff;
      if (len_ff == '0) begin
         cfg.len_idx = '0;
      end else if (len_ff > wbss_pkg::LEN_LIMIT) begin
         cfg.len_idx = wbss_pkg::IDX_W'(wbss_pkg::MAX_PATTERN - 1);
      end else begin
         cfg.len_idx = wbss_pkg::IDX_W'(len_ff - 5'd1);
      end
   end

endmodule

### rtl/core/wbss_front.sv
// input stage: case folding, pattern compare and byte classification
module wbss_front (
   input  wbss_pkg::cfg_type  cfg,
   wbss_req_if.sink           req_chan,
   input  logic               q_ready,
   output logic               push,
   output wbss_pkg::item_type item
);

   logic [wbss_pkg::BYTE_W-1:0] c;

   function automatic logic is_separator(input logic [wbss_pkg::BYTE_W-1:0] b);
      return !(b inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]});
   endfunction

   assign req_chan.ready = q_ready;
   assign push = req_chan.valid && req_chan.ready;

   always_comb begin
      if (cfg.fold_case && (req_chan.data_byte inside {[8'h61:8'h7A]})) begin
         c = req_chan.data_byte - wbss_pkg::CASE_OFFSET;
      end else begin
         c = req_chan.data_byte;
      end
      for (int i = 0; i < wbss_pkg::MAX_PATTERN; i++) begin
         item.eq[i] = (wbss_pkg::IDX_W'(i) <= cfg.len_idx) &&
                      ((cfg.wildcard_enable && (cfg.pattern[i] == wbss_pkg::WILD_BYTE)) ||
                       (cfg.pattern[i] == c));
      end
      item.is_sep = is_separator(c);
      item.is_nl  = (c == wbss_pkg::NEWLINE_BYTE);
      item.first  = req_chan.first_byte;
      item.last   = req_chan.last_byte;
   end

endmodule

### rtl/core/wbss_queue.sv
// short item queue between the input stage and the search engine
module wbss_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  wbss_pkg::item_type push_item,
   output logic               push_ready,
   output logic               pop_valid,
   input  logic               pop,
   output wbss_pkg::item_type pop_item
);

   wbss_pkg::item_type                mem_ff [wbss_pkg::QUEUE_DEPTH];
   logic [wbss_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [wbss_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [wbss_pkg::QCNT_W-1:0]       count_ff, count_in;

   assign push_ready = (count_ff != wbss_pkg::QCNT_W'(wbss_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= wbss_pkg::QCNT_W'(wbss_pkg::QUEUE_DEPTH))
      else $error("queue count past depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) && (count_ff != wbss_pkg::QCNT_W'(wbss_pkg::QUEUE_DEPTH)) |->
      (wr_ptr_ff != rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

### rtl/core/wbss_back.sv
// search engine: shift-and match, line tracking, whole-word check and result register
module wbss_back (
   input  logic               clock,
   input  logic               reset,
   input  wbss_pkg::cfg_type  cfg,
   input  logic               q_valid,
   input  wbss_pkg::item_type q_item,
   output logic               pop,
   wbss_rsp_if.source         rsp_chan
);

   logic [wbss_pkg::MAX_PATTERN-1:0] pmv_ff, pmv_in, c_pmv, shifted;
   logic [wbss_pkg::POS_W-1:0]       pos_ff, pos_in, c_pos;
   logic [wbss_pkg::CNT_W-1:0]       nl_ff, nl_in, c_nl;
   logic [wbss_pkg::LSTART_W-1:0]    ls_ff, ls_in, c_ls;
   logic                             prev_sep_ff, prev_sep_in, c_prev_sep;
   logic                             pending_ff, pending_in, c_pending;
   logic                             done_ff, done_in, c_done;
   logic [wbss_pkg::CNT_W-1:0]       snap_nl_ff, snap_nl_in;
   logic [wbss_pkg::LSTART_W-1:0]    snap_ls_ff, snap_ls_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_found_ff;
   logic [wbss_pkg::POS_W-1:0]       rsp_start_ff;
   logic [wbss_pkg::CNT_W-1:0]       rsp_lines_ff;
   logic [wbss_pkg::LSTART_W-1:0]    rsp_ls_ff;

   logic                             advance, start_bit, emit, emit_found;
   logic [wbss_pkg::POS_W-1:0]       emit_start;
   logic [wbss_pkg::CNT_W-1:0]       emit_lines;
   logic [wbss_pkg::LSTART_W-1:0]    emit_ls;
   logic [wbss_pkg::LSTART_W-1:0]    pos_w, pos_w1, len_w;

   assign advance = q_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign pop     = advance;

   always_comb begin
      c_pmv      = q_item.first ? '0   : pmv_ff;
      c_pos      = q_item.first ? '0   : pos_ff;
      c_nl       = q_item.first ? '0   : nl_ff;
      c_ls       = q_item.first ? '0   : ls_ff;
      c_prev_sep = q_item.first ? 1'b1 : prev_sep_ff;
      c_pending  = q_item.first ? 1'b0 : pending_ff;
      c_done     = q_item.first ? 1'b0 : done_ff;

      pos_w   = {1'b0, c_pos};
      pos_w1  = pos_w + 1'b1;
      len_w   = wbss_pkg::LSTART_W'(cfg.len_idx) + 1'b1;
      start_bit = !cfg.whole_word || c_prev_sep;
      shifted = {c_pmv[wbss_pkg::MAX_PATTERN-2:0], start_bit} & q_item.eq;

      pmv_in      = c_pmv;
      pos_in      = c_pos;
      nl_in       = c_nl;
      ls_in       = c_ls;
      prev_sep_in = c_prev_sep;
      pending_in  = c_pending;
      done_in     = c_done;
      snap_nl_in  = snap_nl_ff;
      snap_ls_in  = snap_ls_ff;
      emit        = 1'b0;
      emit_found  = 1'b0;
      emit_start  = '0;
      emit_lines  = '0;
      emit_ls     = '0;

      if (!c_done) begin
         if (q_item.is_nl) begin
            nl_in = (c_nl == wbss_pkg::CNT_MAX) ? c_nl : c_nl + 1'b1;
            ls_in = pos_w1;
         end
         pending_in = 1'b0;
         if (c_pending && q_item.is_sep) begin
            // delayed whole-word match confirmed by a trailing separator
            done_in    = 1'b1;
            emit       = 1'b1;
            emit_found = 1'b1;
            emit_start = (pos_w >= len_w) ? wbss_pkg::POS_W'(pos_w - len_w) : '0;
            emit_lines = snap_nl_ff;
            emit_ls    = snap_ls_ff;
         end else begin
            pmv_in = shifted;
            if (shifted[cfg.len_idx]) begin
               if (!cfg.whole_word || q_item.last) begin
                  done_in    = 1'b1;
                  emit       = 1'b1;
                  emit_found = 1'b1;
                  emit_start = (pos_w1 >= len_w) ? wbss_pkg::POS_W'(pos_w1 - len_w) : '0;
                  emit_lines = nl_in;
                  emit_ls    = ls_in;
               end else begin
                  pending_in = 1'b1;
                  snap_nl_in = nl_in;
                  snap_ls_in = ls_in;
               end
            end
            if (!emit) begin
               prev_sep_in = q_item.is_sep;
               pos_in = (c_pos == wbss_pkg::POS_MAX) ? c_pos : c_pos + 1'b1;
               if (q_item.last) begin
                  done_in = 1'b1;
                  emit    = 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pmv_ff       <= '0;
         pos_ff       <= '0;
         nl_ff        <= '0;
         ls_ff        <= '0;
         prev_sep_ff  <= 1'b1;
         pending_ff   <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            pmv_ff      <= pmv_in;
            pos_ff      <= pos_in;
            nl_ff       <= nl_in;
            ls_ff       <= ls_in;
            prev_sep_ff <= prev_sep_in;
            pending_ff  <= pending_in;
            done_ff     <= done_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         snap_nl_ff <= snap_nl_in;
         snap_ls_ff <= snap_ls_in;
      end
      if (advance && emit) begin
         rsp_found_ff <= emit_found;
         rsp_start_ff <= emit_start;
         rsp_lines_ff <= emit_lines;
         rsp_ls_ff    <= emit_ls;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.found       = rsp_found_ff;
   assign rsp_chan.match_start = rsp_start_ff;
   assign rsp_chan.line_count  = rsp_lines_ff;
   assign rsp_chan.line_start  = rsp_ls_ff;

   a_pending_not_done: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> !done_ff)
      else $error("pending whole-word match after search end");

   a_done_has_result: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> rsp_valid_ff)
      else $error("search ended without a result");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |->
      (rsp_start_ff == '0) && (rsp_lines_ff == '0) && (rsp_ls_ff == '0))
      else $error("not-found result carries nonzero fields");

endmodule
